// ===== sv/afcr_pkg.sv =====
// Package: shared codes, defaults and control types for the aspect fit/crop adjuster.
`timescale 1ns / 1ps
package afcr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int RES_BITS_DEF  = 14;
    localparam int NUM_RECT      = 8;

    localparam int RIDX_W = 3;
    localparam logic [RIDX_W-1:0] IDX_DST_LEFT   = 3'd0;
    localparam logic [RIDX_W-1:0] IDX_DST_TOP    = 3'd1;
    localparam logic [RIDX_W-1:0] IDX_DST_WIDTH  = 3'd2;
    localparam logic [RIDX_W-1:0] IDX_DST_HEIGHT = 3'd3;
    localparam logic [RIDX_W-1:0] IDX_SRC_LEFT   = 3'd4;
    localparam logic [RIDX_W-1:0] IDX_SRC_TOP    = 3'd5;
    localparam logic [RIDX_W-1:0] IDX_SRC_WIDTH  = 3'd6;
    localparam logic [RIDX_W-1:0] IDX_SRC_HEIGHT = 3'd7;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;

    localparam logic [1:0] MODE_STRETCH = 2'd0;
    localparam logic [1:0] MODE_FIT     = 2'd1;
    localparam logic [1:0] MODE_CROP    = 2'd2;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_DST_W = 3'd1;
    localparam logic [2:0] OP_DST_H = 3'd2;
    localparam logic [2:0] OP_SRC_W = 3'd3;
    localparam logic [2:0] OP_SRC_H = 3'd4;

    typedef logic [2:0] t_op;

    typedef struct packed {
        logic err;
        t_op  op;
    } t_ctl;

endpackage

// ===== sv/afcr_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and hands the beat on.
`timescale 1ns / 1ps
module afcr_div_cell #(
    parameter int CW  = 17,
    parameter int XW  = 62,
    parameter int DW  = 45,
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_v,
    output logic                o_rdy,
    input  logic [8*CW-1:0]     i_rect,
    input  afcr_pkg::t_ctl      i_ctl,
    input  logic [XW-1:0]       i_rem,
    input  logic [DW-1:0]       i_den,
    input  logic [CW-1:0]       i_q,
    input  logic                i_rdy,
    output logic                o_v,
    output logic [8*CW-1:0]     o_rect,
    output afcr_pkg::t_ctl      o_ctl,
    output logic [XW-1:0]       o_rem,
    output logic [DW-1:0]       o_den,
    output logic [CW-1:0]       o_q
);
    import afcr_pkg::*;

    logic            r_v;
    logic [8*CW-1:0] r_rect;
    t_ctl            r_ctl;
    logic [XW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [CW-1:0]   r_q;
    logic [XW-1:0]   shifted;
    logic            ge;
    logic [XW-1:0]   n_rem;
    logic [CW-1:0]   n_q;

    assign shifted = XW'(i_den) << BIT;
    assign ge      = i_rem >= shifted;
    assign n_rem   = ge ? i_rem - shifted : i_rem;
    assign n_q     = i_q | (CW'(ge) << BIT);
    assign o_rdy   = !r_v || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_rdy) begin
            r_v <= i_v;
        end
        if (o_rdy && i_v) begin
            r_rect <= i_rect;
            r_ctl  <= i_ctl;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_q    <= n_q;
        end
    end

    assign o_v    = r_v;
    assign o_rect = r_rect;
    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_q    = r_q;

endmodule

// ===== sv/afcr_fixup.sv =====
// Final cell: for an adjusting operation writes the new extent and centers the position; holds the result beat.
`timescale 1ns / 1ps
module afcr_fixup #(
    parameter int CW = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_v,
    output logic            o_rdy,
    input  logic [8*CW-1:0] i_rect,
    input  afcr_pkg::t_ctl  i_ctl,
    input  logic [CW-1:0]   i_q,
    input  logic            i_stall,
    output logic            o_v,
    output logic [8*CW-1:0] o_rect,
    output logic            o_err
);
    import afcr_pkg::*;

    localparam logic [CW:0] COORD_MAX = {1'b0, {CW{1'b1}}};

    logic            r_v;
    logic [8*CW-1:0] r_rect;
    logic            r_err;
    logic [RIDX_W-1:0] pos_idx;
    logic [RIDX_W-1:0] ext_idx;
    logic            adj;
    logic [CW-1:0]   old_pos;
    logic [CW-1:0]   old_ext;
    logic [CW:0]     diff;
    logic [CW:0]     sum;
    logic [CW-1:0]   new_pos;
    logic [8*CW-1:0] n_rect;

    always_comb begin
        adj     = 1'b1;
        pos_idx = IDX_DST_LEFT;
        ext_idx = IDX_DST_WIDTH;
        unique case (i_ctl.op)
            OP_DST_W: begin pos_idx = IDX_DST_LEFT; ext_idx = IDX_DST_WIDTH;  end
            OP_DST_H: begin pos_idx = IDX_DST_TOP;  ext_idx = IDX_DST_HEIGHT; end
            OP_SRC_W: begin pos_idx = IDX_SRC_LEFT; ext_idx = IDX_SRC_WIDTH;  end
            OP_SRC_H: begin pos_idx = IDX_SRC_TOP;  ext_idx = IDX_SRC_HEIGHT; end
            default:  adj = 1'b0;
        endcase
    end

    assign old_pos = i_rect[pos_idx*CW +: CW];
    assign old_ext = i_rect[ext_idx*CW +: CW];
    assign diff    = {1'b0, old_ext} - {1'b0, i_q};
    assign sum     = {1'b0, old_pos} + {2'b00, diff[CW-1:1]};
    assign new_pos = (diff[CW] || sum > COORD_MAX) ? COORD_MAX[CW-1:0] : sum[CW-1:0];

    always_comb begin
        n_rect = i_rect;
        if (adj) begin
            n_rect[pos_idx*CW +: CW] = new_pos;
            n_rect[ext_idx*CW +: CW] = i_q;
        end
    end

    assign o_rdy = !r_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_rdy) begin
            r_v <= i_v;
        end
        if (o_rdy && i_v) begin
            r_rect <= n_rect;
            r_err  <= i_ctl.err;
        end
    end

    assign o_v    = r_v;
    assign o_rect = r_rect;
    assign o_err  = r_err;

    a_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_v && adj) |-> (i_q < old_ext))
        else $error("new extent not below old extent");
    a_err_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_v && i_ctl.err) |-> !adj)
        else $error("rect adjusted on error");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_v && o_rdy) |=> r_v)
        else $error("beat lost at output");

endmodule

// ===== sv/aspect_fit_crop_rect_adjust.sv =====
// Top level: aspect fit / center crop rectangle adjuster.
// Takes one pair of Q1.FRAC_BITS rectangles per beat and returns one adjusted pair per
// beat, sustaining one item per cycle while the output is not stalled. Four front stages
// (input register, pixel extents, cross products, compare and select) are followed by one
// division cell per quotient bit and the output register. Throughput is set by the cell
// chain, which takes a new beat every cycle unless the output is stalled. Configuration
// writes are always ready and must only be issued while no item is in flight.
`timescale 1ns / 1ps
module aspect_fit_crop_rect_adjust #(
    parameter int FRAC_BITS = afcr_pkg::FRAC_BITS_DEF,
    parameter int RES_BITS  = afcr_pkg::RES_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [afcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RES_BITS-1:0]           i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [FRAC_BITS:0]            i_dst_left,
    input  logic [FRAC_BITS:0]            i_dst_top,
    input  logic [FRAC_BITS:0]            i_dst_width,
    input  logic [FRAC_BITS:0]            i_dst_height,
    input  logic [FRAC_BITS:0]            i_src_left,
    input  logic [FRAC_BITS:0]            i_src_top,
    input  logic [FRAC_BITS:0]            i_src_width,
    input  logic [FRAC_BITS:0]            i_src_height,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [FRAC_BITS:0]            o_out_dst_left,
    output logic [FRAC_BITS:0]            o_out_dst_top,
    output logic [FRAC_BITS:0]            o_out_dst_width,
    output logic [FRAC_BITS:0]            o_out_dst_height,
    output logic [FRAC_BITS:0]            o_out_src_left,
    output logic [FRAC_BITS:0]            o_out_src_top,
    output logic [FRAC_BITS:0]            o_out_src_width,
    output logic [FRAC_BITS:0]            o_out_src_height,
    output logic                          o_zero_extent_error
);
    import afcr_pkg::*;

    localparam int CW = FRAC_BITS + 1;
    localparam int PW = RES_BITS + CW;
    localparam int XW = 2 * PW;
    localparam int DW = PW + RES_BITS;
    localparam int NC = CW;

    // configuration
    logic [RES_BITS-1:0] r_scene_w, r_scene_h, r_source_w, r_source_h;
    logic [1:0]          r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scene_w  <= RES_BITS'(1920);
            r_scene_h  <= RES_BITS'(1080);
            r_source_w <= RES_BITS'(1920);
            r_source_h <= RES_BITS'(1080);
            r_mode     <= MODE_STRETCH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCENE_W:  r_scene_w  <= i_cfg_data;
                CFG_SCENE_H:  r_scene_h  <= i_cfg_data;
                CFG_SOURCE_W: r_source_w <= i_cfg_data;
                CFG_SOURCE_H: r_source_h <= i_cfg_data;
                CFG_MODE:     r_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage A: input register
    logic            r_a_v;
    logic [8*CW-1:0] r_a_rect;
    logic            a_rdy, b_rdy, c_rdy, d_rdy;

    assign a_rdy   = !r_a_v || b_rdy;
    assign o_stall = !a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_rdy) begin
            r_a_v <= i_valid;
        end
        if (a_rdy && i_valid) begin
            r_a_rect <= {i_src_height, i_src_width, i_src_top, i_src_left,
                         i_dst_height, i_dst_width, i_dst_top, i_dst_left};
        end
    end

    // stage B: pixel extents
    logic            r_b_v;
    logic [8*CW-1:0] r_b_rect;
    logic [PW-1:0]   r_b_dw, r_b_dh, r_b_sw, r_b_sh;

    assign b_rdy = !r_b_v || c_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_rdy) begin
            r_b_v <= r_a_v;
        end
        if (b_rdy && r_a_v) begin
            r_b_rect <= r_a_rect;
            r_b_dw   <= PW'(r_scene_w)  * PW'(r_a_rect[IDX_DST_WIDTH*CW +: CW]);
            r_b_dh   <= PW'(r_scene_h)  * PW'(r_a_rect[IDX_DST_HEIGHT*CW +: CW]);
            r_b_sw   <= PW'(r_source_w) * PW'(r_a_rect[IDX_SRC_WIDTH*CW +: CW]);
            r_b_sh   <= PW'(r_source_h) * PW'(r_a_rect[IDX_SRC_HEIGHT*CW +: CW]);
        end
    end

    // stage C: cross products and candidate divisors
    logic            r_c_v;
    logic [8*CW-1:0] r_c_rect;
    logic [XW-1:0]   r_c_dx, r_c_sx;
    logic [DW-1:0]   r_c_den_w, r_c_den_t;
    logic            r_c_err, r_c_act;
    logic            fit, act, zero;
    logic [PW-1:0]   wa, ta;
    logic [RES_BITS-1:0] wb, tb;

    assign fit  = r_mode == MODE_FIT;
    assign act  = fit || r_mode == MODE_CROP;
    assign zero = r_b_dw == '0 || r_b_dh == '0 || r_b_sw == '0 || r_b_sh == '0;
    assign wa   = fit ? r_b_sh : r_b_dw;
    assign wb   = fit ? r_scene_w : r_source_h;
    assign ta   = fit ? r_b_sw : r_b_dh;
    assign tb   = fit ? r_scene_h : r_source_w;
    assign c_rdy = !r_c_v || d_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (c_rdy) begin
            r_c_v <= r_b_v;
        end
        if (c_rdy && r_b_v) begin
            r_c_rect  <= r_b_rect;
            r_c_dx    <= XW'(r_b_dw) * XW'(r_b_sh);
            r_c_sx    <= XW'(r_b_sw) * XW'(r_b_dh);
            r_c_den_w <= DW'(wa) * DW'(wb);
            r_c_den_t <= DW'(ta) * DW'(tb);
            r_c_err   <= act && zero;
            r_c_act   <= act && !zero;
        end
    end

    // stage D: aspect compare and operation select
    logic            r_d_v;
    logic [8*CW-1:0] r_d_rect;
    t_ctl            r_d_ctl;
    logic [XW-1:0]   r_d_num;
    logic [DW-1:0]   r_d_den;
    t_ctl            n_ctl;
    logic [XW-1:0]   n_num;
    logic [DW-1:0]   n_den;
    logic            wider, taller;

    assign wider = r_c_dx > r_c_sx;
    assign taller = r_c_sx > r_c_dx;

    always_comb begin
        n_ctl.err = r_c_err;
        n_ctl.op  = OP_NONE;
        n_num     = r_c_sx;
        n_den     = r_c_den_w;
        priority if (r_c_act && wider) begin
            n_ctl.op = fit ? OP_DST_W : OP_SRC_H;
        end else if (r_c_act && taller) begin
            n_ctl.op = fit ? OP_DST_H : OP_SRC_W;
            n_num    = r_c_dx;
            n_den    = r_c_den_t;
        end else begin
            n_ctl.op = OP_NONE;
        end
    end

    logic cell_rdy [NC+1];

    assign d_rdy = !r_d_v || cell_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (d_rdy) begin
            r_d_v <= r_c_v;
        end
        if (d_rdy && r_c_v) begin
            r_d_rect <= r_c_rect;
            r_d_ctl  <= n_ctl;
            r_d_num  <= n_num;
            r_d_den  <= n_den;
        end
    end

    // division chain, most significant quotient bit first
    logic            cv    [NC+1];
    logic [8*CW-1:0] crect [NC+1];
    t_ctl            cctl  [NC+1];
    logic [XW-1:0]   crem  [NC+1];
    logic [DW-1:0]   cden  [NC+1];
    logic [CW-1:0]   cq    [NC+1];

    assign cv[0]    = r_d_v;
    assign crect[0] = r_d_rect;
    assign cctl[0]  = r_d_ctl;
    assign crem[0]  = r_d_num;
    assign cden[0]  = r_d_den;
    assign cq[0]    = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        afcr_div_cell #(
            .CW (CW),
            .XW (XW),
            .DW (DW),
            .BIT(NC - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_v    (cv[k]),
            .o_rdy  (cell_rdy[k]),
            .i_rect (crect[k]),
            .i_ctl  (cctl[k]),
            .i_rem  (crem[k]),
            .i_den  (cden[k]),
            .i_q    (cq[k]),
            .i_rdy  (cell_rdy[k+1]),
            .o_v    (cv[k+1]),
            .o_rect (crect[k+1]),
            .o_ctl  (cctl[k+1]),
            .o_rem  (crem[k+1]),
            .o_den  (cden[k+1]),
            .o_q    (cq[k+1])
        );
    end

    logic [8*CW-1:0] out_rect;

    afcr_fixup #(
        .CW(CW)
    ) u_fixup (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_v    (cv[NC]),
        .o_rdy  (cell_rdy[NC]),
        .i_rect (crect[NC]),
        .i_ctl  (cctl[NC]),
        .i_q    (cq[NC]),
        .i_stall(i_stall),
        .o_v    (o_valid),
        .o_rect (out_rect),
        .o_err  (o_zero_extent_error)
    );

    assign o_out_dst_left   = out_rect[IDX_DST_LEFT*CW +: CW];
    assign o_out_dst_top    = out_rect[IDX_DST_TOP*CW +: CW];
    assign o_out_dst_width  = out_rect[IDX_DST_WIDTH*CW +: CW];
    assign o_out_dst_height = out_rect[IDX_DST_HEIGHT*CW +: CW];
    assign o_out_src_left   = out_rect[IDX_SRC_LEFT*CW +: CW];
    assign o_out_src_top    = out_rect[IDX_SRC_TOP*CW +: CW];
    assign o_out_src_width  = out_rect[IDX_SRC_WIDTH*CW +: CW];
    assign o_out_src_height = out_rect[IDX_SRC_HEIGHT*CW +: CW];

    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_v && r_d_ctl.op != OP_NONE) |-> (r_d_den != '0))
        else $error("division issued with zero divisor");
    a_err_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_v && r_d_ctl.err) |-> (r_d_ctl.op == OP_NONE))
        else $error("operation selected on zero extent");
    a_stretch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && !act) |-> (!r_c_err && !r_c_act))
        else $error("stretch mode flagged or adjusted");

endmodule
